// ----- hw/rtl/lsb_stego_extract_deframe_top_assert.svh -----
// Assertion helpers shared by the deframer modules.
// Each use expects clk in scope; LSED_ASSERT also expects rst_n.
`ifndef LSB_STEGO_EXTRACT_DEFRAME_TOP_ASSERT_SVH
`define LSB_STEGO_EXTRACT_DEFRAME_TOP_ASSERT_SVH

// Checked only outside reset.
`define LSED_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define LSED_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/lsed_pkg.sv -----
`default_nettype none

package lsed_pkg;

    localparam int NUM_LANES = 3;
    localparam int MARK_MAX  = 16;

    localparam logic [1:0] ST_RUN       = 2'd0;
    localparam logic [1:0] ST_END_FOUND = 2'd1;
    localparam logic [1:0] ST_START_BAD = 2'd2;
    localparam logic [1:0] ST_NO_END    = 2'd3;

    localparam logic [7:0] START_MARK [MARK_MAX] = '{
        8'h70, 8'h65, 8'h65, 8'h70, 8'h6f, 8'h73, 8'h74, 8'h61,
        8'h72, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] END_MARK [MARK_MAX] = '{
        8'h70, 8'h65, 8'h65, 8'h70, 8'h6f, 8'h65, 8'h6e, 8'h64,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // What one bit lane contributes to the byte under assembly.
    typedef struct packed {
        logic [7:0] mask;
        logic       hit;
    } lane_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] payload_byte;
        logic [1:0] status;
        logic       done_res;
    } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lsed_pix_if.sv -----
`default_nettype none

interface lsed_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;

    modport source (output valid, output red, output green, output blue,
                    output last_pixel, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input last_pixel, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lsed_res_if.sv -----
`default_nettype none

interface lsed_res_if;
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] payload_byte;
    logic [1:0] status;
    logic       done_res;

    modport source (output valid, output byte_valid, output payload_byte,
                    output status, output done_res, input ready);
    modport sink   (input valid, input byte_valid, input payload_byte,
                    input status, input done_res, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lsed_lane.sv -----
`default_nettype none

module lsed_lane
    import lsed_pkg::*;
#(
    parameter int LANE = 0
)
(
    input  wire logic [2:0] bit_pos,
    input  wire logic       data_bit,
    output lane_t           lane
);

    logic [2:0] pos;

    // Each lane sits LANE places below the pixel's first bit, modulo 8.
    assign pos       = bit_pos - 3'(LANE);
    assign lane.mask = data_bit ? (8'd1 << pos) : 8'd0;
    assign lane.hit  = (pos == 3'd0);

endmodule

`default_nettype wire

// ----- hw/rtl/lsed_core.sv -----
`default_nettype none
`include "lsb_stego_extract_deframe_top_assert.svh"

module lsed_core
    import lsed_pkg::*;
#(
    parameter int START_MARK_LEN = 10,
    parameter int END_MARK_LEN   = 8
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       acc,
    input  wire logic [2:0] pix_bits,
    input  wire logic       pix_last,
    input  wire logic       chk_start,
    output logic            res_valid,
    output res_t            res
);

    localparam int HC_W   = $clog2(START_MARK_LEN + 1);
    localparam int FILL_W = $clog2(END_MARK_LEN + 1);

    logic [2:0]        bp_reg, bp_next;
    logic [7:0]        partial_reg, partial_next;
    logic [HC_W-1:0]   hdr_reg, hdr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              fin_reg, fin_next;
    logic [7:0]        win_reg [END_MARK_LEN];
    logic [7:0]        win_next [END_MARK_LEN];

    lane_t             lanes [NUM_LANES];
    logic [7:0]        early, late;
    logic              byte_done;
    logic [3:0]        hdr_ext;
    logic              hdr_active, full, push, leave, mismatch, end_found, match_all;
    logic [1:0]        status;

    for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
        lsed_lane #(.LANE(c)) u_lane (
            .bit_pos  (bp_reg),
            .data_bit (pix_bits[NUM_LANES-1-c]),
            .lane     (lanes[c])
        );
    end

    // Merge: bits up to the completing lane close the byte, the rest open the next.
    always_comb
    begin
        early     = partial_reg;
        late      = 8'd0;
        byte_done = 1'b0;
        for (int c = 0; c < NUM_LANES; c++)
        begin
            if (byte_done)
                late = late | lanes[c].mask;
            else
                early = early | lanes[c].mask;
            byte_done = byte_done | lanes[c].hit;
        end
    end

    // Only read while the header is active, so four bits always cover it.
    assign hdr_ext    = 4'(hdr_reg);
    assign hdr_active = (hdr_reg < HC_W'(START_MARK_LEN));
    assign full       = (fill_reg == FILL_W'(END_MARK_LEN));

    always_comb
    begin
        bp_next      = bp_reg;
        partial_next = partial_reg;
        hdr_next     = hdr_reg;
        fill_next    = fill_reg;
        fin_next     = fin_reg;
        push         = 1'b0;
        leave        = 1'b0;
        mismatch     = 1'b0;
        status       = ST_RUN;
        if (acc && !fin_reg)
        begin
            bp_next = bp_reg - 3'(NUM_LANES);
            if (byte_done)
            begin
                partial_next = late;
                if (hdr_active)
                begin
                    hdr_next = hdr_reg + HC_W'(1);
                    mismatch = chk_start && (early != START_MARK[hdr_ext]);
                end
                else
                begin
                    push = 1'b1;
                    if (full)
                        leave = 1'b1;
                    else
                        fill_next = fill_reg + FILL_W'(1);
                end
            end
            else
            begin
                partial_next = early;
            end
        end
        end_found = push && (fill_next == FILL_W'(END_MARK_LEN)) && match_all;
        if (acc && !fin_reg)
        begin
            fin_next = mismatch || end_found;
            if (mismatch)
                status = ST_START_BAD;
            else if (end_found)
                status = ST_END_FOUND;
            else if (pix_last)
                status = ST_NO_END;
        end
        // Last pixel: drop the image state (bit position, partial byte, counts, finish) for the next image.
        if (acc && pix_last)
        begin
            bp_next      = 3'd7;
            partial_next = 8'd0;
            hdr_next     = '0;
            fill_next    = '0;
            fin_next     = 1'b0;
        end
    end

    // Hold-back window: newest byte enters at the top, oldest leaves at entry 0.
    always_comb
    begin
        win_next = win_reg;
        if (push)
        begin
            for (int i = 0; i < END_MARK_LEN - 1; i++)
                win_next[i] = win_reg[i+1];
            win_next[END_MARK_LEN-1] = early;
        end
    end

    always_comb
    begin
        match_all = 1'b1;
        for (int i = 0; i < END_MARK_LEN; i++)
            match_all = match_all & (win_next[i] == END_MARK[i]);
    end

    assign res_valid        = acc && (leave || (status != ST_RUN));
    assign res.byte_valid   = leave;
    assign res.payload_byte = leave ? win_reg[0] : 8'd0;
    assign res.status       = status;
    assign res.done_res     = (status != ST_RUN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_reg      <= 3'd7;
            partial_reg <= 8'd0;
            hdr_reg     <= '0;
            fill_reg    <= '0;
            fin_reg     <= 1'b0;
        end
        else
        begin
            bp_reg      <= bp_next;
            partial_reg <= partial_next;
            hdr_reg     <= hdr_next;
            fill_reg    <= fill_next;
            fin_reg     <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    `LSED_ASSERT(a_quiet_after_finish, (acc && fin_reg && !pix_last) |-> !res_valid, "result after finish")
    `LSED_ASSERT(a_last_clears, (acc && pix_last) |=> (bp_reg == 3'd7 && fill_reg == '0 && !fin_reg), "image state not cleared")
    `LSED_ASSERT(a_leave_needs_full, (res_valid && res.byte_valid) |-> full, "byte left a window not full")

endmodule

`default_nettype wire

// ----- hw/rtl/lsb_stego_extract_deframe_top.sv -----
// Channel | Dir | Payload                                  | Transfer
// pix     | in  | red, green, blue, last_pixel             | valid & ready
// res     | out | byte_valid, payload_byte, status, done_res | valid & ready
// cfg     | in  | cfg_wr_data (check_start_mark)           | cfg_wr_en
//
// One pixel per clock while pix.ready is high; a pixel's result is visible in the cycle after its transfer.
// All per-pixel work (three bit lanes, merge, 8-byte window compare) fits in
// the accepting cycle; the only storage between the sides is the output register.
// pix.ready drops only while a result sits in the output register and res.ready is low.
// rst_n is asynchronous; after reset check_start_mark is 1 and no clearing pass runs.
`default_nettype none
`include "lsb_stego_extract_deframe_top_assert.svh"

module lsb_stego_extract_deframe_top
    import lsed_pkg::*;
#(
    parameter int START_MARK_LEN = 10,
    parameter int END_MARK_LEN   = 8
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_wr_en,
    input  wire logic   cfg_wr_data,
    lsed_pix_if.sink    pix,
    lsed_res_if.source  res
);

    logic chk_reg;
    logic out_vld_reg, out_vld_next;
    res_t out_reg;
    logic acc;
    logic core_vld;
    res_t core_res;

    // Take a pixel whenever the output register is empty or drains this cycle.
    assign pix.ready = !out_vld_reg || res.ready;
    assign acc       = pix.valid && pix.ready;

    lsed_core #(
        .START_MARK_LEN (START_MARK_LEN),
        .END_MARK_LEN   (END_MARK_LEN)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .pix_bits  ({pix.red[0], pix.green[0], pix.blue[0]}),
        .pix_last  (pix.last_pixel),
        .chk_start (chk_reg),
        .res_valid (core_vld),
        .res       (core_res)
    );

    // Hold the result until transfer; load a new one if this pixel makes one.
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (res.ready)
            out_vld_next = 1'b0;
        if (core_vld)
            out_vld_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_reg     <= 1'b1;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                chk_reg <= cfg_wr_data;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_vld)
            out_reg <= core_res;
    end

    assign res.valid        = out_vld_reg;
    assign res.byte_valid   = out_reg.byte_valid;
    assign res.payload_byte = out_reg.payload_byte;
    assign res.status       = out_reg.status;
    assign res.done_res     = out_reg.done_res;

    `LSED_ASSERT(a_no_take_when_stalled, (res.valid && !res.ready) |-> !pix.ready, "pixel taken over a stalled result")
    `LSED_ASSERT(a_res_held, (res.valid && !res.ready) |=> $stable(out_reg), "stalled result moved")
    `LSED_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !res.valid || rst_n, "output valid out of reset")

endmodule

`default_nettype wire
